// ===== design/tfn_pkg.sv =====
// tfn_pkg: shared constants and types of the triangle face normal block
// no dependencies; used by every module under design/

package tfn_pkg;

    localparam int COORD_WIDTH_DEF = 16;   // default corner coordinate width
    localparam int QUEUE_DEPTH_DEF = 4;    // default depth of the cross product queue
    localparam int NORM_BITS       = 15;   // magnitude bits of a q1.14 component (0..16384)
    localparam int OUT_WIDTH       = 16;   // width of a normal component
    localparam int NORM_SHIFT      = 30;   // 2^30 scale of the rounding test

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_SEARCH
    } back_state_t;

endpackage

// ===== design/tfn_front.sv =====
// tfn_front: edge subtraction and partial products registered, cross differences combinational
// depends on tfn_pkg for the default coordinate width

module tfn_front #(
    parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [COORD_WIDTH-1:0]     corner_a_x,
    input  logic signed [COORD_WIDTH-1:0]     corner_a_y,
    input  logic signed [COORD_WIDTH-1:0]     corner_a_z,
    input  logic signed [COORD_WIDTH-1:0]     corner_b_x,
    input  logic signed [COORD_WIDTH-1:0]     corner_b_y,
    input  logic signed [COORD_WIDTH-1:0]     corner_b_z,
    input  logic signed [COORD_WIDTH-1:0]     corner_c_x,
    input  logic signed [COORD_WIDTH-1:0]     corner_c_y,
    input  logic signed [COORD_WIDTH-1:0]     corner_c_z,
    output logic                              out_valid,
    output logic signed [2*COORD_WIDTH+2:0]   cross_x,
    output logic signed [2*COORD_WIDTH+2:0]   cross_y,
    output logic signed [2*COORD_WIDTH+2:0]   cross_z
);

    localparam int EW = COORD_WIDTH + 1;
    localparam int PW = 2 * COORD_WIDTH + 2;
    localparam int CW = 2 * COORD_WIDTH + 3;

    logic                 v1_reg;
    logic                 v2_reg;
    logic signed [EW-1:0] e1x_reg, e1y_reg, e1z_reg;
    logic signed [EW-1:0] e2x_reg, e2y_reg, e2z_reg;
    logic signed [PW-1:0] p_yz_reg, p_zy_reg, p_zx_reg, p_xz_reg, p_xy_reg, p_yx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // edges from the first corner
    always_ff @(posedge clk)
    begin
        e1x_reg <= EW'(corner_b_x) - EW'(corner_a_x);
        e1y_reg <= EW'(corner_b_y) - EW'(corner_a_y);
        e1z_reg <= EW'(corner_b_z) - EW'(corner_a_z);
        e2x_reg <= EW'(corner_c_x) - EW'(corner_a_x);
        e2y_reg <= EW'(corner_c_y) - EW'(corner_a_y);
        e2z_reg <= EW'(corner_c_z) - EW'(corner_a_z);
    end

    // six partial products of the cross product
    always_ff @(posedge clk)
    begin
        p_yz_reg <= PW'(e1y_reg) * PW'(e2z_reg);
        p_zy_reg <= PW'(e1z_reg) * PW'(e2y_reg);
        p_zx_reg <= PW'(e1z_reg) * PW'(e2x_reg);
        p_xz_reg <= PW'(e1x_reg) * PW'(e2z_reg);
        p_xy_reg <= PW'(e1x_reg) * PW'(e2y_reg);
        p_yx_reg <= PW'(e1y_reg) * PW'(e2x_reg);
    end

    assign out_valid = v2_reg;
    assign cross_x   = CW'(p_yz_reg) - CW'(p_zy_reg);
    assign cross_y   = CW'(p_zx_reg) - CW'(p_xz_reg);
    assign cross_z   = CW'(p_xy_reg) - CW'(p_yx_reg);

endmodule

// ===== design/tfn_fifo.sv =====
// tfn_fifo: small register queue of cross products between front and back
// depends on tfn_pkg for the default depth

module tfn_fifo #(
    parameter int DATA_WIDTH  = 105,
    parameter int QUEUE_DEPTH = tfn_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [DATA_WIDTH-1:0] push_data,
    input  logic                  pop,
    output logic                  not_empty,
    output logic [DATA_WIDTH-1:0] pop_data
);

    localparam int PTW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CNW-1:0]        count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

endmodule

// ===== design/tfn_back.sv =====
// tfn_back: sequencer that squares the cross components bit-serially and
// searches the rounded q1.14 components bit by bit; depends on tfn_pkg

module tfn_back #(
    parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  logic [3*(2*COORD_WIDTH+3)-1:0]      q_data,
    output logic                                q_pop,
    output logic                                done,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0] normal_x,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0] normal_y,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0] normal_z,
    output logic                                degenerate
);

    localparam int CW  = 2 * COORD_WIDTH + 3;   // signed cross component
    localparam int MW  = CW - 1;                // its magnitude
    localparam int QW  = 2 * MW;                // square of a component
    localparam int SW  = QW + 2;                // sum of three squares
    localparam int AW  = SW + 34;               // search accumulators
    localparam int NB  = tfn_pkg::NORM_BITS;
    localparam int OW  = tfn_pkg::OUT_WIDTH;
    localparam int CTW = $clog2(MW + 1);

    tfn_pkg::back_state_t state_reg, state_next;
    logic [CTW-1:0]       cnt_reg, cnt_next;
    logic                 done_reg;

    logic [MW-1:0]  mag_reg   [3];
    logic [MW-1:0]  shift_reg [3];
    logic           neg_reg   [3];
    logic [QW-1:0]  sq_reg    [3];
    logic [SW-1:0]  s_reg;
    logic [AW-1:0]  s2k_reg;
    logic [AW-1:0]  sk_reg;
    logic [AW-1:0]  a_reg     [3];
    logic [AW-1:0]  b_reg     [3];
    logic [AW-1:0]  bk_reg    [3];
    logic [NB-1:0]  n_reg     [3];
    logic signed [OW-1:0] res_reg [3];
    logic           degen_reg;

    logic signed [CW-1:0] cin   [3];
    logic [AW-1:0]  a_cand [3];
    logic [AW-1:0]  b_cand [3];
    logic           ok     [3];
    logic [NB-1:0]  n_fin  [3];
    logic [SW-1:0]  s_sum;
    logic           search_last;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tfn_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = tfn_pkg::ST_SQUARE;
                end
            end
            tfn_pkg::ST_SQUARE:
            begin
                if (cnt_reg == CTW'(MW - 1))
                begin
                    state_next = tfn_pkg::ST_SUM;
                end
            end
            tfn_pkg::ST_SUM:
            begin
                state_next = tfn_pkg::ST_SEARCH;
            end
            tfn_pkg::ST_SEARCH:
            begin
                if (search_last)
                begin
                    state_next = tfn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tfn_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop    = 1'b0;
        cnt_next = cnt_reg;
        unique case (state_reg)
            tfn_pkg::ST_IDLE:
            begin
                q_pop    = q_valid;
                cnt_next = '0;
            end
            tfn_pkg::ST_SQUARE:
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            tfn_pkg::ST_SUM:
            begin
                cnt_next = CTW'(NB - 1);
            end
            tfn_pkg::ST_SEARCH:
            begin
                cnt_next = cnt_reg - 1'b1;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    assign search_last = (state_reg == tfn_pkg::ST_SEARCH) && (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tfn_pkg::ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= search_last;
        end
    end

    // candidate step of the bit search per lane
    always_comb
    begin
        s_sum = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            cin[i]    = signed'(q_data[i*CW +: CW]);
            a_cand[i] = a_reg[i] + (bk_reg[i] << 1) + s2k_reg;
            b_cand[i] = b_reg[i] + sk_reg;
            ok[i]     = ((a_cand[i] << 2) + AW'(s_reg))
                        <= ((AW'(sq_reg[i]) << tfn_pkg::NORM_SHIFT) + (b_cand[i] << 2));
            n_fin[i]  = {n_reg[i][NB-2:0], ok[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            tfn_pkg::ST_IDLE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i]   <= cin[i][CW-1];
                    mag_reg[i]   <= cin[i][CW-1] ? MW'(-cin[i]) : MW'(cin[i]);
                    shift_reg[i] <= cin[i][CW-1] ? MW'(-cin[i]) : MW'(cin[i]);
                    sq_reg[i]    <= '0;
                end
            end
            tfn_pkg::ST_SQUARE:
            begin
                // msb-first shift and add square
                for (int i = 0; i < 3; i++)
                begin
                    sq_reg[i]    <= (sq_reg[i] << 1)
                                    + (shift_reg[i][MW-1] ? QW'(mag_reg[i]) : '0);
                    shift_reg[i] <= shift_reg[i] << 1;
                end
            end
            tfn_pkg::ST_SUM:
            begin
                s_reg   <= s_sum;
                s2k_reg <= AW'(s_sum) << (2 * (NB - 1));
                sk_reg  <= AW'(s_sum) << (NB - 1);
                for (int i = 0; i < 3; i++)
                begin
                    a_reg[i]  <= '0;
                    b_reg[i]  <= '0;
                    bk_reg[i] <= '0;
                    n_reg[i]  <= '0;
                end
            end
            tfn_pkg::ST_SEARCH:
            begin
                s2k_reg <= s2k_reg >> 2;
                sk_reg  <= sk_reg >> 1;
                for (int i = 0; i < 3; i++)
                begin
                    n_reg[i] <= n_fin[i];
                    if (ok[i])
                    begin
                        a_reg[i]  <= a_cand[i];
                        b_reg[i]  <= b_cand[i];
                        bk_reg[i] <= (bk_reg[i] + s2k_reg) >> 1;
                    end
                    else
                    begin
                        bk_reg[i] <= bk_reg[i] >> 1;
                    end
                end
                if (search_last)
                begin
                    degen_reg <= (s_reg == '0);
                    for (int i = 0; i < 3; i++)
                    begin
                        if (s_reg == '0)
                        begin
                            res_reg[i] <= '0;
                        end
                        else if (neg_reg[i])
                        begin
                            res_reg[i] <= -signed'(OW'(n_fin[i]));
                        end
                        else
                        begin
                            res_reg[i] <= signed'(OW'(n_fin[i]));
                        end
                    end
                end
            end
            default:
            begin
                s_reg <= s_reg;
            end
        endcase
    end

    assign done       = done_reg;
    assign normal_x   = res_reg[0];
    assign normal_y   = res_reg[1];
    assign normal_z   = res_reg[2];
    assign degenerate = degen_reg;

endmodule

// ===== design/triangle_face_normal_top.sv =====
// triangle_face_normal_top: unit face normal of one triangle, q8.8 in, q1.14 out
// the back sequencer works on one triangle at a time, paced by the serial squarer and the
// 15-step bit search; the queue absorbs bursts of QUEUE_DEPTH triangles
// reset: rst_n async active low empties the queue and idles the sequencer; done drops
// results are shown on done for one cycle; the receiver cannot stall them

module triangle_face_normal_top #(
    parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF,
    parameter int QUEUE_DEPTH = tfn_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [COORD_WIDTH-1:0]        corner_a_x,
    input  logic signed [COORD_WIDTH-1:0]        corner_a_y,
    input  logic signed [COORD_WIDTH-1:0]        corner_a_z,
    input  logic signed [COORD_WIDTH-1:0]        corner_b_x,
    input  logic signed [COORD_WIDTH-1:0]        corner_b_y,
    input  logic signed [COORD_WIDTH-1:0]        corner_b_z,
    input  logic signed [COORD_WIDTH-1:0]        corner_c_x,
    input  logic signed [COORD_WIDTH-1:0]        corner_c_y,
    input  logic signed [COORD_WIDTH-1:0]        corner_c_z,
    output logic                                 done,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0] normal_x,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0] normal_y,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0] normal_z,
    output logic                                 degenerate
);

    localparam int CW  = 2 * COORD_WIDTH + 3;
    localparam int DW  = 3 * CW;
    localparam int OCW = $clog2(QUEUE_DEPTH + 1);

    logic                 accept;
    logic                 front_valid;
    logic signed [CW-1:0] cross_x, cross_y, cross_z;
    logic                 q_not_empty;
    logic [DW-1:0]        q_rd_data;
    logic                 q_pop;
    logic [OCW-1:0]       occ_reg, occ_next;

    // a transfer is taken only when a queue slot is reserved for it, so the
    // front pipeline never has to stall
    assign accept = start && !busy;
    assign busy   = (occ_reg == OCW'(QUEUE_DEPTH));

    always_comb
    begin
        occ_next = occ_reg;
        if (accept && !q_pop)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (q_pop && !accept)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // edges, products and cross differences
    tfn_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .corner_a_x (corner_a_x),
        .corner_a_y (corner_a_y),
        .corner_a_z (corner_a_z),
        .corner_b_x (corner_b_x),
        .corner_b_y (corner_b_y),
        .corner_b_z (corner_b_z),
        .corner_c_x (corner_c_x),
        .corner_c_y (corner_c_y),
        .corner_c_z (corner_c_z),
        .out_valid  (front_valid),
        .cross_x    (cross_x),
        .cross_y    (cross_y),
        .cross_z    (cross_z)
    );

    // cross products wait here for the normalizer
    tfn_fifo #(
        .DATA_WIDTH  (DW),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_data ({cross_z, cross_y, cross_x}),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_rd_data)
    );

    // squaring, sum and rounded normalization
    tfn_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_not_empty),
        .q_data     (q_rd_data),
        .q_pop      (q_pop),
        .done       (done),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z),
        .degenerate (degenerate)
    );

endmodule
